### rtl/rcvg_pkg.sv
// Shared types, constants and helper functions for the rounded cube vertex generator.
package rcvg_pkg;

   localparam int CORDIC_ITERATIONS_DEF = 16;
   localparam int MAX_STEPS_DEF         = 64;

   localparam int STEPS_W   = 7;
   localparam int RADIUS_W  = 17;
   localparam int RING_W    = 7;
   localparam int SEG_W     = 8;
   localparam int INDEX_W   = 15;
   localparam int Q14_W     = 16;
   localparam int MAG_W     = 9;
   localparam int PHASE_W   = 32;
   localparam int DVD_W     = 38;
   localparam int CORD_W    = 34;
   localparam int TRIG_W    = 32;
   localparam int CSR_IDX_W = 2;
   localparam int FIFO_DEPTH = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_STEPS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTH_RADIUS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MESH_SCALE    = 2'd2;

   localparam logic [STEPS_W-1:0]  STEPS_RESET  = 7'd10;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 17'd32768;
   localparam logic [RADIUS_W-1:0] SCALE_RESET  = 17'd32768;
   localparam logic [RADIUS_W-1:0] ONE_Q16      = 17'd65536;

   localparam logic signed [CORD_W-1:0] CORDIC_X0 = 34'sd652032874;

   typedef struct packed {
      logic [STEPS_W-1:0]  steps;
      logic [RADIUS_W-1:0] radius;
      logic [RADIUS_W-1:0] scale;
   } cfg_type;

   typedef struct packed {
      logic               err;
      logic [INDEX_W-1:0] vertex_index;
      logic               alpha_neg;
      logic [MAG_W-1:0]   alpha_mag;
      logic [MAG_W-1:0]   beta_mag;
   } work_type;

   typedef struct packed {
      logic [INDEX_W-1:0]      vertex_index;
      logic signed [Q14_W-1:0] pos_x;
      logic signed [Q14_W-1:0] pos_y;
      logic signed [Q14_W-1:0] pos_z;
      logic signed [Q14_W-1:0] norm_x;
      logic signed [Q14_W-1:0] norm_y;
      logic signed [Q14_W-1:0] norm_z;
      logic                    range_error;
   } result_type;

   // arctangent of 2^-k in phase units, 2^32 = full turn
   function automatic logic [31:0] atan_phase(input int k);
      logic [31:0] v;
      case (k)
         0:  v = 32'd536870912;
         1:  v = 32'd316933406;
         2:  v = 32'd167458907;
         3:  v = 32'd85004756;
         4:  v = 32'd42667331;
         5:  v = 32'd21354465;
         6:  v = 32'd10679838;
         7:  v = 32'd5340245;
         8:  v = 32'd2670163;
         9:  v = 32'd1335087;
         10: v = 32'd667544;
         11: v = 32'd333772;
         12: v = 32'd166886;
         13: v = 32'd83443;
         14: v = 32'd41722;
         15: v = 32'd20861;
         16: v = 32'd10430;
         17: v = 32'd5215;
         18: v = 32'd2608;
         19: v = 32'd1304;
         20: v = 32'd652;
         21: v = 32'd326;
         22: v = 32'd163;
         23: v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [Q14_W-1:0] clamp_q14(input logic signed [63:0] v);
      logic signed [Q14_W-1:0] r;
      if (v > 64'sd16384) r = 16'sd16384;
      else if (v < -64'sd16384) r = -16'sd16384;
      else r = v[Q14_W-1:0];
      return r;
   endfunction

endpackage

### rtl/rcvg_fifo.sv
// Small register queue used between front and back and on the result side.
module rcvg_fifo
   import rcvg_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = FIFO_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == (AW+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

### rtl/rcvg_front.sv
// Front part: accepts requests, checks grid bounds and forms the angle numerators.
module rcvg_front
   import rcvg_pkg::*;
(
   input  logic              req_push,
   input  logic [RING_W-1:0] req_ring,
   input  logic [SEG_W-1:0]  req_segment,
   output logic              req_full,
   input  cfg_type           cfg,
   input  logic              mid_full,
   output logic              mid_push,
   output work_type          mid_data
);
   logic [STEPS_W-1:0] st;
   logic [15:0]        vi_full;

   assign req_full = mid_full;
   assign mid_push = req_push && !mid_full;

   always_comb begin
      st = cfg.steps;
      mid_data.err = (st == '0) ||
                     ({1'b0, req_ring} >= {st, 1'b0}) ||
                     ({1'b0, req_segment} >= {st, 2'b00});
      vi_full = 16'(req_ring) * 16'({st, 2'b00}) + 16'(req_segment);
      mid_data.vertex_index = vi_full[INDEX_W-1:0];
      // latitude numerator 2*ring - 2*s + 1, kept as sign and magnitude
      if (req_ring >= st) begin
         mid_data.alpha_neg = 1'b0;
         mid_data.alpha_mag = {1'b0, req_ring - st, 1'b1};
      end else begin
         mid_data.alpha_neg = 1'b1;
         mid_data.alpha_mag = {1'b0, st - req_ring - 7'd1, 1'b1};
      end
      mid_data.beta_mag = {req_segment, 1'b1};
   end

endmodule

### rtl/rcvg_div.sv
// Pipelined restoring divider: phase = round(mag * 2^29 / steps), one quotient bit per stage.
module rcvg_div
   import rcvg_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic [MAG_W-1:0]   mag,
   input  logic               neg,
   input  logic [STEPS_W-1:0] steps,
   output logic [PHASE_W-1:0] phase
);
   localparam int SHIFT = DVD_W - MAG_W;

   logic [DVD_W-1:0]   dvd_ff [DVD_W+1];
   logic [DVD_W-1:0]   quo_ff [DVD_W+1];
   logic [STEPS_W-1:0] rem_ff [DVD_W+1];
   logic               neg_ff [DVD_W+1];
   logic [PHASE_W-1:0] phase_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         dvd_ff[0] <= {mag, {SHIFT{1'b0}}} + DVD_W'(steps >> 1);
         quo_ff[0] <= '0;
         rem_ff[0] <= '0;
         neg_ff[0] <= neg;
      end
   end

   for (genvar i = 0; i < DVD_W; i++) begin : g_bit
      logic [STEPS_W:0] trial;
      logic [STEPS_W:0] diff;
      logic             ge;
      always_comb begin
         trial = {rem_ff[i], dvd_ff[i][DVD_W-1]};
         ge    = trial >= {1'b0, steps};
         diff  = trial - {1'b0, steps};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            dvd_ff[i+1] <= {dvd_ff[i][DVD_W-2:0], 1'b0};
            quo_ff[i+1] <= {quo_ff[i][DVD_W-2:0], ge};
            rem_ff[i+1] <= ge ? diff[STEPS_W-1:0] : trial[STEPS_W-1:0];
            neg_ff[i+1] <= neg_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         phase_ff <= neg_ff[DVD_W] ? (PHASE_W'(0) - quo_ff[DVD_W][PHASE_W-1:0])
                                   : quo_ff[DVD_W][PHASE_W-1:0];
      end
   end

   assign phase = phase_ff;

endmodule

### rtl/rcvg_cordic.sv
// Pipelined rotation CORDIC, one iteration per stage, with half-turn folding.
module rcvg_cordic
   import rcvg_pkg::*;
#(
   parameter int ITER = CORDIC_ITERATIONS_DEF
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [PHASE_W-1:0]       phase,
   output logic signed [TRIG_W-1:0] cos_q,
   output logic signed [TRIG_W-1:0] sin_q
);
   localparam logic signed [PHASE_W:0] QUARTER = 33'sd1073741824;
   localparam logic signed [PHASE_W:0] HALF    = 33'sd2147483648;

   logic signed [CORD_W-1:0] x_ff [ITER+1];
   logic signed [CORD_W-1:0] y_ff [ITER+1];
   logic signed [CORD_W-1:0] z_ff [ITER+1];
   logic                     flip_ff [ITER+1];
   logic signed [TRIG_W-1:0] cos_ff, sin_ff;
   logic signed [PHASE_W:0]  t;
   logic                     flip;

   always_comb begin
      t    = $signed({phase[PHASE_W-1], phase});
      flip = 1'b0;
      if (t > QUARTER) begin
         t    = t - HALF;
         flip = 1'b1;
      end else if (t < -QUARTER) begin
         t    = t + HALF;
         flip = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= CORDIC_X0;
         y_ff[0]    <= '0;
         z_ff[0]    <= CORD_W'(t);
         flip_ff[0] <= flip;
      end
   end

   for (genvar k = 0; k < ITER; k++) begin : g_iter
      localparam logic signed [CORD_W-1:0] ATAN_K = $signed({2'b00, atan_phase(k)});
      always_ff @(posedge clock) begin
         if (en) begin
            if (z_ff[k] >= 0) begin
               x_ff[k+1] <= x_ff[k] - (y_ff[k] >>> k);
               y_ff[k+1] <= y_ff[k] + (x_ff[k] >>> k);
               z_ff[k+1] <= z_ff[k] - ATAN_K;
            end else begin
               x_ff[k+1] <= x_ff[k] + (y_ff[k] >>> k);
               y_ff[k+1] <= y_ff[k] - (x_ff[k] >>> k);
               z_ff[k+1] <= z_ff[k] + ATAN_K;
            end
            flip_ff[k+1] <= flip_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= flip_ff[ITER] ? TRIG_W'(-x_ff[ITER]) : TRIG_W'(x_ff[ITER]);
         sin_ff <= flip_ff[ITER] ? TRIG_W'(-y_ff[ITER]) : TRIG_W'(y_ff[ITER]);
      end
   end

   assign cos_q = cos_ff;
   assign sin_q = sin_ff;

endmodule

### rtl/rcvg_back.sv
// Back part: angle division, sine/cosine, normal products and rounded-cube position.
module rcvg_back
   import rcvg_pkg::*;
#(
   parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       mid_empty,
   input  work_type   mid_data,
   output logic       mid_pop,
   input  logic       out_full,
   output logic       out_push,
   output result_type out_data
);
   localparam int DIV_LAT  = DVD_W + 2;
   localparam int COR_LAT  = CORDIC_ITERATIONS + 2;
   localparam int POST_LAT = 5;
   localparam int LAT      = DIV_LAT + COR_LAT + POST_LAT;

   localparam logic signed [63:0] RND46 = 64'sd35184372088832;
   localparam logic signed [63:0] RND32 = 64'sd2147483648;
   localparam logic signed [63:0] RND16 = 64'sd32768;

   logic     valid_ff [LAT];
   work_type tag_ff   [LAT];
   logic     adv;
   logic     tail_valid;

   logic [PHASE_W-1:0]       phase_a, phase_b;
   logic signed [TRIG_W-1:0] ca, sa, cb, sb;

   logic signed [63:0]       pxx_ff, pxz_ff;
   logic signed [TRIG_W-1:0] sa_ff;
   logic signed [Q14_W-1:0]  n2_ff [3];
   logic signed [Q14_W-1:0]  n3_ff [3];
   logic signed [Q14_W-1:0]  n4_ff [3];
   logic signed [35:0]       inner_ff [3];
   logic signed [53:0]       prod_ff [3];
   logic signed [Q14_W-1:0]  pos_ff [3];
   logic signed [Q14_W-1:0]  nout_ff [3];

   logic [RADIUS_W-1:0]      one_minus_r;
   logic signed [35:0]       corner;

   assign tail_valid = valid_ff[LAT-1];
   assign adv        = !(tail_valid && out_full);
   assign mid_pop    = adv && !mid_empty;
   assign out_push   = tail_valid && !out_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) valid_ff[i] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= !mid_empty;
         for (int i = 1; i < LAT; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff[0] <= mid_data;
         for (int i = 1; i < LAT; i++) tag_ff[i] <= tag_ff[i-1];
      end
   end

   rcvg_div u_div_a (
      .clock (clock),
      .en    (adv),
      .mag   (mid_data.alpha_mag),
      .neg   (mid_data.alpha_neg),
      .steps (cfg.steps),
      .phase (phase_a)
   );

   rcvg_div u_div_b (
      .clock (clock),
      .en    (adv),
      .mag   (mid_data.beta_mag),
      .neg   (1'b0),
      .steps (cfg.steps),
      .phase (phase_b)
   );

   rcvg_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_a (
      .clock (clock),
      .en    (adv),
      .phase (phase_a),
      .cos_q (ca),
      .sin_q (sa)
   );

   rcvg_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_b (
      .clock (clock),
      .en    (adv),
      .phase (phase_b),
      .cos_q (cb),
      .sin_q (sb)
   );

   assign one_minus_r = ONE_Q16 - cfg.radius;
   assign corner      = $signed({5'b0, one_minus_r, 14'b0});

   always_ff @(posedge clock) begin
      if (adv) begin
         // normal products, Q30 x Q30
         pxx_ff <= 64'(ca) * 64'(cb);
         pxz_ff <= 64'(ca) * 64'(sb);
         sa_ff  <= sa;
         // round to Q14 and clamp
         n2_ff[0] <= clamp_q14((pxx_ff + RND46) >>> 46);
         n2_ff[1] <= clamp_q14((64'(sa_ff) + RND16) >>> 16);
         n2_ff[2] <= clamp_q14((pxz_ff + RND46) >>> 46);
         for (int j = 0; j < 3; j++) begin
            // r*n plus the cube corner term (1-r)*sgn(n)
            if (n2_ff[j] > 0)
               inner_ff[j] <= 36'($signed({1'b0, cfg.radius})) * 36'(n2_ff[j]) + corner;
            else if (n2_ff[j] < 0)
               inner_ff[j] <= 36'($signed({1'b0, cfg.radius})) * 36'(n2_ff[j]) - corner;
            else
               inner_ff[j] <= '0;
            n3_ff[j]   <= n2_ff[j];
            prod_ff[j] <= 54'(inner_ff[j]) * 54'($signed({1'b0, cfg.scale}));
            n4_ff[j]   <= n3_ff[j];
            pos_ff[j]  <= clamp_q14((64'(prod_ff[j]) + RND32) >>> 32);
            nout_ff[j] <= n4_ff[j];
         end
      end
   end

   always_comb begin
      out_data.range_error = tag_ff[LAT-1].err;
      if (tag_ff[LAT-1].err) begin
         out_data.vertex_index = '0;
         out_data.pos_x  = '0;
         out_data.pos_y  = '0;
         out_data.pos_z  = '0;
         out_data.norm_x = '0;
         out_data.norm_y = '0;
         out_data.norm_z = '0;
      end else begin
         out_data.vertex_index = tag_ff[LAT-1].vertex_index;
         out_data.pos_x  = pos_ff[0];
         out_data.pos_y  = pos_ff[1];
         out_data.pos_z  = pos_ff[2];
         out_data.norm_x = nout_ff[0];
         out_data.norm_y = nout_ff[1];
         out_data.norm_z = nout_ff[2];
      end
   end

endmodule

### rtl/rounded_cube_vertex_generator.sv
// Top level of the rounded cube vertex generator: config registers, front, queues, back.
//
//   channel   direction  handshake              payload
//   req       in         req_push / req_full    req_ring, req_segment
//   rsp       out        rsp_pop / rsp_empty    vertex index, position, normal, range_error
//   csr       in         csr_write              csr_index, csr_data
//
// One request enters per cycle while req_full is low; its result reaches the rsp ports
// through the 38-stage bit-per-stage angle dividers, the one-iteration-per-stage CORDIC
// and the two queues. Reset is synchronous; it empties both queues and the back
// pipeline valid line. A full result queue freezes the whole back pipeline while its
// tail holds a valid item; the front queue then fills and raises req_full. Out-of-grid
// requests pass through the same pipeline with range_error.
module rounded_cube_vertex_generator
   import rcvg_pkg::*;
#(
   parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF,
   parameter int MAX_STEPS         = MAX_STEPS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic [RING_W-1:0]        req_ring,
   input  logic [SEG_W-1:0]         req_segment,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic [INDEX_W-1:0]       rsp_vertex_index,
   output logic signed [Q14_W-1:0]  rsp_pos_x,
   output logic signed [Q14_W-1:0]  rsp_pos_y,
   output logic signed [Q14_W-1:0]  rsp_pos_z,
   output logic signed [Q14_W-1:0]  rsp_norm_x,
   output logic signed [Q14_W-1:0]  rsp_norm_y,
   output logic signed [Q14_W-1:0]  rsp_norm_z,
   output logic                     rsp_range_error,
   input  logic                     csr_write,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [RADIUS_W-1:0]      csr_data
);
   logic [STEPS_W-1:0]  angle_steps_ff;
   logic [RADIUS_W-1:0] smooth_radius_ff;
   logic [RADIUS_W-1:0] mesh_scale_ff;
   cfg_type             cfg;

   logic       mid_push, mid_full, mid_pop, mid_empty;
   work_type   mid_in, mid_out;
   logic       out_push, out_full;
   result_type out_in, out_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_steps_ff   <= STEPS_RESET;
         smooth_radius_ff <= RADIUS_RESET;
         mesh_scale_ff    <= SCALE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ANGLE_STEPS:   angle_steps_ff   <= csr_data[STEPS_W-1:0];
            CSR_SMOOTH_RADIUS: smooth_radius_ff <= csr_data;
            CSR_MESH_SCALE:    mesh_scale_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // saturated working copies of the registers
   always_comb begin
      cfg.steps  = (angle_steps_ff > STEPS_W'(MAX_STEPS)) ? STEPS_W'(MAX_STEPS)
                                                         : angle_steps_ff;
      cfg.radius = (smooth_radius_ff > ONE_Q16) ? ONE_Q16 : smooth_radius_ff;
      cfg.scale  = (mesh_scale_ff > ONE_Q16) ? ONE_Q16 : mesh_scale_ff;
   end

   rcvg_front u_front (
      .req_push    (req_push),
      .req_ring    (req_ring),
      .req_segment (req_segment),
      .req_full    (req_full),
      .cfg         (cfg),
      .mid_full    (mid_full),
      .mid_push    (mid_push),
      .mid_data    (mid_in)
   );

   rcvg_fifo #(.WIDTH($bits(work_type)), .DEPTH(FIFO_DEPTH)) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_in),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_out),
      .empty     (mid_empty)
   );

   rcvg_back #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .mid_empty (mid_empty),
      .mid_data  (mid_out),
      .mid_pop   (mid_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_in)
   );

   rcvg_fifo #(.WIDTH($bits(result_type)), .DEPTH(FIFO_DEPTH)) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_in),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (out_data),
      .empty     (rsp_empty)
   );

   assign rsp_vertex_index = out_data.vertex_index;
   assign rsp_pos_x        = out_data.pos_x;
   assign rsp_pos_y        = out_data.pos_y;
   assign rsp_pos_z        = out_data.pos_z;
   assign rsp_norm_x       = out_data.norm_x;
   assign rsp_norm_y       = out_data.norm_y;
   assign rsp_norm_z       = out_data.norm_z;
   assign rsp_range_error  = out_data.range_error;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_range_error) |->
         (rsp_vertex_index == '0 && rsp_pos_x == '0 && rsp_pos_y == '0 &&
          rsp_pos_z == '0 && rsp_norm_x == '0 && rsp_norm_y == '0 && rsp_norm_z == '0))
      else $error("range error item with nonzero fields");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_norm_x <= 16'sd16384 && rsp_norm_x >= -16'sd16384 &&
                      rsp_norm_z <= 16'sd16384 && rsp_norm_z >= -16'sd16384))
      else $error("normal out of clamp range");

   a_zero_axis: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_range_error && rsp_norm_y == '0) |-> (rsp_pos_y == '0))
      else $error("zero normal axis gave nonzero position");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the rounded cube vertex generator.
`timescale 1ns / 1ps

module tb_top;
   import rcvg_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 80;

   typedef struct {
      int         ring;
      int         seg;
      bit         known;
      result_type res;
   } vec_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_push = 1'b0;
   logic                    req_full;
   logic [RING_W-1:0]       req_ring = '0;
   logic [SEG_W-1:0]        req_segment = '0;
   logic                    rsp_empty;
   logic                    rsp_pop = 1'b0;
   logic [INDEX_W-1:0]      rsp_vertex_index;
   logic signed [Q14_W-1:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [Q14_W-1:0] rsp_norm_x, rsp_norm_y, rsp_norm_z;
   logic                    rsp_range_error;
   logic                    csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [RADIUS_W-1:0]     csr_data = '0;

   // table value travels with the item so the acceptance edge sees the right one
   logic       drv_known = 1'b0;
   result_type drv_res = '0;

   logic [STEPS_W-1:0]  steps_reg = STEPS_RESET;
   logic [RADIUS_W-1:0] radius_reg = RADIUS_RESET;
   logic [RADIUS_W-1:0] scale_reg = SCALE_RESET;

   result_type vertex_q[$];
   int  errors = 0;
   int  n_sent = 0;
   int  n_recv = 0;
   int  n_oob = 0;
   int  idle_cnt = 0;
   bit  send_idle = 0;
   bit  recv_stall = 0;
   int  idle_pct = 57;
   int  hold_reqs = 0;
   int  hold_seen = 0;
   int  hold_cnt = 0;

   longint atan_tab[16] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                            10679838, 5340245, 2670163, 1335087, 667544, 333772,
                            166886, 83443, 41722, 20861};

   rounded_cube_vertex_generator dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint clip14(longint v);
      if (v > 16384) return 16384;
      if (v < -16384) return -16384;
      return v;
   endfunction

   function automatic logic [31:0] angle_of(longint d, longint st);
      longint unsigned mag, q;
      mag = (d < 0 ? -d : d) << 29;
      q = ((mag + st / 2) / st) & 64'hFFFF_FFFF;
      return d < 0 ? 32'd0 - q[31:0] : q[31:0];
   endfunction

   task automatic rotate(input logic [31:0] ph, output longint c, output longint s);
      longint t, x, y, z, nx;
      bit flip;
      t = 64'(ph);
      flip = 0;
      x = 652032874;
      y = 0;
      if (t >= 64'sd2147483648) t -= 64'sd4294967296;
      if (t > 64'sd1073741824) begin
         t -= 64'sd2147483648;
         flip = 1;
      end else if (t < -64'sd1073741824) begin
         t += 64'sd2147483648;
         flip = 1;
      end
      z = t;
      for (int k = 0; k < CORDIC_ITERATIONS_DEF; k++) begin
         if (z >= 0) begin
            nx = x - (y >>> k); y = y + (x >>> k); z -= atan_tab[k];
         end else begin
            nx = x + (y >>> k); y = y - (x >>> k); z += atan_tab[k];
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic longint place(longint n, longint r, longint sc);
      longint sg, inner;
      sg = n > 0 ? 1 : (n < 0 ? -1 : 0);
      inner = r * n + (65536 - r) * sg * 16384;
      return clip14((inner * sc + 64'sd2147483648) >>> 32);
   endfunction

   task automatic predict_vertex(input int ring, input int seg, output result_type res);
      longint st, r, sc, ca, sa, cb, sb, nx, ny, nz;
      st = steps_reg > MAX_STEPS_DEF ? MAX_STEPS_DEF : steps_reg;
      r = radius_reg > ONE_Q16 ? ONE_Q16 : radius_reg;
      sc = scale_reg > ONE_Q16 ? ONE_Q16 : scale_reg;
      res = '0;
      if (st == 0 || ring >= 2 * st || seg >= 4 * st) begin
         res.range_error = 1'b1;
         return;
      end
      rotate(angle_of(2 * ring - 2 * st + 1, st), ca, sa);
      rotate(angle_of(2 * seg + 1, st), cb, sb);
      nx = clip14((ca * cb + (64'sd1 << 45)) >>> 46);
      ny = clip14((sa + 32768) >>> 16);
      nz = clip14((ca * sb + (64'sd1 << 45)) >>> 46);
      res.vertex_index = INDEX_W'(ring * 4 * st + seg);
      res.pos_x = Q14_W'(place(nx, r, sc));
      res.pos_y = Q14_W'(place(ny, r, sc));
      res.pos_z = Q14_W'(place(nz, r, sc));
      res.norm_x = Q14_W'(nx);
      res.norm_y = Q14_W'(ny);
      res.norm_z = Q14_W'(nz);
   endtask

   // expectation recorded at the edge that accepts the item
   always @(posedge clock) begin
      result_type res;
      if (!reset && req_push && !req_full) begin
         if (drv_known) res = drv_res;
         else predict_vertex(req_ring, req_segment, res);
         vertex_q.push_back(res);
         n_sent++;
         if (res.range_error) n_oob++;
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         n_recv++;
         if (vertex_q.size() == 0) begin
            $display("%0t: unexpected item, vertex_index %0d", $time, rsp_vertex_index);
            errors++;
         end else begin
            want = vertex_q.pop_front();
            if (rsp_vertex_index !== want.vertex_index) begin
               $display("%0t: vertex_index exp %0d got %0d", $time, want.vertex_index,
                        rsp_vertex_index);
               errors++;
            end
            if (rsp_pos_x !== want.pos_x) begin
               $display("%0t: pos_x exp %0d got %0d", $time, want.pos_x, rsp_pos_x);
               errors++;
            end
            if (rsp_pos_y !== want.pos_y) begin
               $display("%0t: pos_y exp %0d got %0d", $time, want.pos_y, rsp_pos_y);
               errors++;
            end
            if (rsp_pos_z !== want.pos_z) begin
               $display("%0t: pos_z exp %0d got %0d", $time, want.pos_z, rsp_pos_z);
               errors++;
            end
            if (rsp_norm_x !== want.norm_x) begin
               $display("%0t: norm_x exp %0d got %0d", $time, want.norm_x, rsp_norm_x);
               errors++;
            end
            if (rsp_norm_y !== want.norm_y) begin
               $display("%0t: norm_y exp %0d got %0d", $time, want.norm_y, rsp_norm_y);
               errors++;
            end
            if (rsp_norm_z !== want.norm_z) begin
               $display("%0t: norm_z exp %0d got %0d", $time, want.norm_z, rsp_norm_z);
               errors++;
            end
            if (rsp_range_error !== want.range_error) begin
               $display("%0t: range_error exp %0b got %0b", $time, want.range_error,
                        rsp_range_error);
               errors++;
            end
         end
      end
   end

   // result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_reqs != hold_seen) begin
         hold_seen = hold_reqs;
         hold_cnt <= HOLD_CYCLES;
         rsp_pop <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= recv_stall ? ($urandom_range(99) >= idle_pct) : 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= STALL_LIMIT) begin
         $display("%0t: watchdog expired, %0d items outstanding", $time, vertex_q.size());
         $display("FAIL rounded_cube_vertex_generator");
         $finish;
      end
   end

   task automatic csr_set(input logic [CSR_IDX_W-1:0] idx, input int val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= RADIUS_W'(val);
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_ANGLE_STEPS:   steps_reg = STEPS_W'(val);
         CSR_SMOOTH_RADIUS: radius_reg = RADIUS_W'(val);
         CSR_MESH_SCALE:    scale_reg = RADIUS_W'(val);
         default: ;
      endcase
   endtask

   // drives one item and returns after the edge that accepts it
   task automatic send_vertex(input int ring, input int seg, input bit known,
                              input result_type res);
      if (send_idle && $urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_ring <= RING_W'(ring);
      req_segment <= SEG_W'(seg);
      drv_known <= known;
      drv_res <= res;
      do @(posedge clock); while (req_full);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      // let the monitor record the item accepted at the last edge
      @(posedge clock);
      while (vertex_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_vertex();
      int st, ring, seg;
      st = steps_reg > MAX_STEPS_DEF ? MAX_STEPS_DEF : steps_reg;
      if (st > 0 && $urandom_range(99) < 85) begin
         ring = $urandom_range(2 * st - 1);
         seg = $urandom_range(4 * st - 1);
      end else begin
         ring = $urandom_range(127);
         seg = $urandom_range(255);
      end
      send_vertex(ring, seg, 0, '0);
   endtask

   initial begin
      vec_type vecs[$];
      result_type oob;
      int n;
      oob = '0;
      oob.range_error = 1'b1;
      vecs = '{
         '{0, 0, 0, '0}, '{19, 39, 0, '0}, '{10, 0, 0, '0}, '{9, 20, 0, '0},
         '{19, 0, 0, '0}, '{0, 39, 0, '0}, '{5, 17, 0, '0}, '{10, 10, 0, '0},
         '{20, 0, 1, oob}, '{0, 40, 1, oob}, '{127, 255, 1, oob}, '{19, 40, 1, oob},
         '{64, 128, 1, oob}, '{1, 1, 0, '0}, '{18, 38, 0, '0}, '{15, 33, 0, '0}
      };
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (vecs[i]) send_vertex(vecs[i].ring, vecs[i].seg, vecs[i].known, vecs[i].res);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin
               csr_set(CSR_ANGLE_STEPS, 64);
               csr_set(CSR_SMOOTH_RADIUS, 65536);
               csr_set(CSR_MESH_SCALE, 65536);
            end
            1: begin
               csr_set(CSR_ANGLE_STEPS, 1);
               csr_set(CSR_SMOOTH_RADIUS, 0);
               csr_set(CSR_MESH_SCALE, 0);
            end
            2: begin
               // oversize values: steps clamp, radius and scale saturate
               csr_set(CSR_ANGLE_STEPS, 127);
               csr_set(CSR_SMOOTH_RADIUS, 17'h1FFFF);
               csr_set(CSR_MESH_SCALE, 17'h1FFFF);
            end
            3: csr_set(CSR_ANGLE_STEPS, 0);
            4: begin
               csr_set(CSR_ANGLE_STEPS, 10);
               csr_set(CSR_SMOOTH_RADIUS, 32768);
               csr_set(CSR_MESH_SCALE, 32768);
               csr_set(CSR_MESH_SCALE + 2'd1, 17'h1FFFF);
            end
            default: begin
               csr_set(CSR_ANGLE_STEPS, $urandom_range(127));
               csr_set(CSR_SMOOTH_RADIUS, $urandom_range(17'h1FFFF));
               csr_set(CSR_MESH_SCALE, $urandom_range(17'h1FFFF));
            end
         endcase
         send_idle = ph[0];
         recv_stall = ph[1];
         idle_pct = (ph[0] && ph[1]) ? 30 : 57;
         n = ph == 3 ? 80 : 195;
         for (int i = 0; i < n; i++) begin
            if (ph == 2 && i == 20) hold_reqs++;
            if (ph == 5 && i == 100) drain();
            random_vertex();
         end
         drain();
      end

      req_push <= 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d items (%0d out of grid), checked %0d results", n_sent, n_oob, n_recv);
      $display("Covered step counts 0..127, radius/scale extremes, stalls and a long hold-off");
      if (errors == 0 && vertex_q.size() == 0) begin
         $display("PASS rounded_cube_vertex_generator");
      end else begin
         $display("FAIL rounded_cube_vertex_generator");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/rcvg_pkg.sv
rtl/rcvg_fifo.sv
rtl/rcvg_front.sv
rtl/rcvg_div.sv
rtl/rcvg_cordic.sv
rtl/rcvg_back.sv
rtl/rounded_cube_vertex_generator.sv
tb/tb_top.sv
